// ===== design/dle_pkg.sv =====
`default_nettype none

package dle_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAKE_TREE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAKE_TXN  = 2'd1;

  // Operation codes of a request.
  localparam logic [2:0] OP_TREE_APPEND = 3'd0;
  localparam logic [2:0] OP_OVR_ALL     = 3'd1;
  localparam logic [2:0] OP_OVERWRITE   = 3'd2;
  localparam logic [2:0] OP_INSERT      = 3'd3;
  localparam logic [2:0] OP_ERASE       = 3'd4;
  localparam logic [2:0] OP_CLEAR       = 3'd5;
  localparam logic [2:0] OP_READ        = 3'd6;

  // Placement of an inserted duplicate.
  localparam logic [1:0] PM_LAST   = 2'd0;
  localparam logic [1:0] PM_FIRST  = 2'd1;
  localparam logic [1:0] PM_BEFORE = 2'd2;
  localparam logic [1:0] PM_AFTER  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BADREF  = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  // One stored list entry.
  typedef struct packed {
    logic        from_tree;
    logic [31:0] handle;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [2:0]  opcode;
    logic [1:0]  place_mode;
    logic [6:0]  ref_index;
    logic [31:0] handle;
    logic        visible;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  entry_count;
    logic        entry_from_tree;
    logic [31:0] entry_handle;
  } rsp_t;

endpackage

`default_nettype wire

// ===== design/duplicate_list_editor.sv =====
// Duplicate list editor: an ordered list of up to DEPTH entries, each a
// tree/transaction source bit and a 32-bit handle, held in one RAM.
// Requests come in on in_valid_i/in_stall_o with in_data_i; every request
// gives exactly one response on out_valid_o/out_stall_i with out_data_o
// (status, entry count after the request, and the entry for a read).
// Two enable bits are written through cfg_valid_i/cfg_ready_o, index 0
// enabling tree appends and index 1 enabling transaction requests; write
// them only while no request is in flight.
// Sequence: a positional insert or erase first shifts each moved entry
// through the RAM, one RAM read and one RAM write per cycle; then the new
// entry is written or the referenced entry read, and the response is
// loaded. The next request is taken only after the response is loaded.
// Reset empties the list and sets both enables; the RAM needs no clearing
// since only entries below the count are ever read.
// A stalled response stays in the output register; a new request may be
// accepted meanwhile, and its response waits until the register frees.
`default_nettype none

module duplicate_list_editor #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire dle_pkg::req_t                  in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output dle_pkg::rsp_t                       out_data_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [dle_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic                           cfg_data_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic            take_tree_q;
  logic            take_txn_q;
  logic            ram_wr_en;
  logic [AW-1:0]   ram_wr_addr;
  dle_pkg::entry_t ram_wr_data;
  logic            ram_rd_en;
  logic [AW-1:0]   ram_rd_addr;
  dle_pkg::entry_t ram_rd_data;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      take_tree_q <= 1'b1;
      take_txn_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == dle_pkg::CFG_TAKE_TREE) begin
        take_tree_q <= cfg_data_i;
      end
      if (cfg_index_i == dle_pkg::CFG_TAKE_TXN) begin
        take_txn_q <= cfg_data_i;
      end
    end
  end

  // Entry storage.
  dle_ram #(
    .WIDTH(dle_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (ram_wr_en),
    .wr_addr_i(ram_wr_addr),
    .wr_data_i(ram_wr_data),
    .rd_en_i  (ram_rd_en),
    .rd_addr_i(ram_rd_addr),
    .rd_data_o(ram_rd_data)
  );

  // Decode and shift sequencer.
  dle_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_tree_i  (take_tree_q),
    .take_txn_i   (take_txn_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .ram_wr_en_o  (ram_wr_en),
    .ram_wr_addr_o(ram_wr_addr),
    .ram_wr_data_o(ram_wr_data),
    .ram_rd_en_o  (ram_rd_en),
    .ram_rd_addr_o(ram_rd_addr),
    .ram_rd_data_i(ram_rd_data)
  );

endmodule

`default_nettype wire

// ===== design/dle_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module dle_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/dle_seq.sv =====
`default_nettype none

// Request decode and list sequencer. Shifts entries through the RAM one per
// cycle, then writes the new entry or reads the referenced one.
module dle_seq #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            take_tree_i,
  input  wire logic            take_txn_i,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire dle_pkg::req_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output dle_pkg::rsp_t        out_data_o,
  output logic                 ram_wr_en_o,
  output logic [AW-1:0]        ram_wr_addr_o,
  output dle_pkg::entry_t      ram_wr_data_o,
  output logic                 ram_rd_en_o,
  output logic [AW-1:0]        ram_rd_addr_o,
  input  wire dle_pkg::entry_t ram_rd_data_i
);

  localparam int unsigned XW = ((CW > 7) ? CW : 7) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_RESP
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   next_count_q;
  logic [1:0]      status_q;
  logic [CW-1:0]   moves_q;
  logic [AW-1:0]   rd_idx_q;
  logic            down_q;
  logic            pend_q;
  logic [AW-1:0]   pend_addr_q;
  logic            wr_new_q;
  logic            rd_q;
  logic [AW-1:0]   pos_q;
  logic [31:0]     handle_q;
  logic            from_tree_q;
  logic            out_valid_q;
  dle_pkg::rsp_t   out_data_q;

  logic            accept;
  logic            issue;
  logic            finish;
  logic            out_free;

  // Decode results.
  logic [XW-1:0]   ref_x;
  logic [XW-1:0]   cnt_x;
  logic [XW-1:0]   pos_x;
  logic            full;
  logic            txn_op;
  logic [1:0]      dec_status;
  logic [CW-1:0]   dec_count;
  logic            dec_ins;
  logic            dec_ers;
  logic            dec_wr;
  logic            dec_rd;
  logic            dec_tree;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign issue    = (state_q == S_SHIFT) && (moves_q != '0);
  assign finish   = (state_q == S_SHIFT) && (moves_q == '0) && !pend_q;
  assign out_free = !out_valid_q || !out_stall_i;

  // Decode one request against the current entry count.
  always_comb begin
    ref_x      = XW'(in_data_i.ref_index);
    cnt_x      = XW'(count_q);
    full       = (count_q == CW'(DEPTH));
    txn_op     = (in_data_i.opcode == dle_pkg::OP_OVR_ALL) ||
                 (in_data_i.opcode == dle_pkg::OP_OVERWRITE) ||
                 (in_data_i.opcode == dle_pkg::OP_INSERT) ||
                 (in_data_i.opcode == dle_pkg::OP_ERASE);
    pos_x      = '0;
    dec_status = dle_pkg::ST_OK;
    dec_count  = count_q;
    dec_ins    = 1'b0;
    dec_ers    = 1'b0;
    dec_wr     = 1'b0;
    dec_rd     = 1'b0;
    dec_tree   = 1'b0;
    if (txn_op && (!take_txn_i || !in_data_i.visible)) begin
      dec_status = dle_pkg::ST_IGNORED;
    end else begin
      unique case (in_data_i.opcode)
        dle_pkg::OP_TREE_APPEND: begin
          if (!take_tree_i) begin
            dec_status = dle_pkg::ST_IGNORED;
          end else if (full) begin
            dec_status = dle_pkg::ST_FULL;
          end else begin
            dec_ins   = 1'b1;
            dec_tree  = 1'b1;
            pos_x     = cnt_x;
            dec_count = CW'(cnt_x + XW'(1));
          end
        end
        dle_pkg::OP_OVR_ALL: begin
          dec_wr    = 1'b1;
          dec_count = CW'(1);
        end
        dle_pkg::OP_OVERWRITE: begin
          if (ref_x == '0) begin
            dec_wr    = 1'b1;
            dec_count = CW'(1);
          end else if (ref_x > cnt_x) begin
            dec_status = dle_pkg::ST_BADREF;
          end else begin
            dec_wr = 1'b1;
            pos_x  = ref_x - XW'(1);
          end
        end
        dle_pkg::OP_INSERT: begin
          if ((in_data_i.place_mode == dle_pkg::PM_BEFORE) &&
              ((ref_x == '0) || (ref_x > cnt_x + XW'(1)))) begin
            dec_status = dle_pkg::ST_BADREF;
          end else if (full) begin
            dec_status = dle_pkg::ST_FULL;
          end else begin
            dec_ins   = 1'b1;
            dec_count = CW'(cnt_x + XW'(1));
            unique case (in_data_i.place_mode)
              dle_pkg::PM_LAST:   pos_x = cnt_x;
              dle_pkg::PM_FIRST:  pos_x = '0;
              dle_pkg::PM_BEFORE: pos_x = ref_x - XW'(1);
              dle_pkg::PM_AFTER:  pos_x = (ref_x >= cnt_x) ? cnt_x : ref_x;
              default:            pos_x = cnt_x;
            endcase
          end
        end
        dle_pkg::OP_ERASE: begin
          if (ref_x == '0) begin
            dec_count = '0;
          end else if (ref_x > cnt_x) begin
            dec_status = dle_pkg::ST_BADREF;
          end else begin
            dec_ers   = 1'b1;
            pos_x     = ref_x - XW'(1);
            dec_count = CW'(cnt_x - XW'(1));
          end
        end
        dle_pkg::OP_CLEAR: begin
          dec_count = '0;
        end
        dle_pkg::OP_READ: begin
          if ((ref_x == '0) || (ref_x > cnt_x)) begin
            dec_status = dle_pkg::ST_BADREF;
          end else begin
            dec_rd = 1'b1;
            pos_x  = ref_x - XW'(1);
          end
        end
        default: begin
          dec_status = dle_pkg::ST_IGNORED;
        end
      endcase
    end
  end

  // RAM read port: shift reads, then the final read of a read request.
  assign ram_rd_en_o   = issue || (finish && rd_q);
  assign ram_rd_addr_o = issue ? rd_idx_q : pos_q;

  // RAM write port: a pending shift write goes first, the new entry last.
  always_comb begin
    ram_wr_en_o   = 1'b0;
    ram_wr_addr_o = pend_addr_q;
    ram_wr_data_o = ram_rd_data_i;
    if (pend_q) begin
      ram_wr_en_o = 1'b1;
    end else if (finish && wr_new_q) begin
      ram_wr_en_o             = 1'b1;
      ram_wr_addr_o           = pos_q;
      ram_wr_data_o.from_tree = from_tree_q;
      ram_wr_data_o.handle    = handle_q;
    end
  end

  // Sequencer state, count and response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      moves_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // A new response loads the register; a taken one empties it.
      if ((state_q == S_RESP) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      pend_q <= issue;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q      <= S_SHIFT;
            status_q     <= dec_status;
            next_count_q <= dec_count;
            wr_new_q     <= dec_ins || dec_wr;
            rd_q         <= dec_rd;
            pos_q        <= AW'(pos_x);
            handle_q     <= in_data_i.handle;
            from_tree_q  <= dec_tree;
            down_q       <= dec_ins;
            if (dec_ins) begin
              moves_q  <= CW'(cnt_x - pos_x);
              rd_idx_q <= AW'(cnt_x - XW'(1));
            end else if (dec_ers) begin
              moves_q  <= CW'(cnt_x - ref_x);
              rd_idx_q <= AW'(ref_x);
            end else begin
              moves_q <= '0;
            end
          end
        end
        S_SHIFT: begin
          if (issue) begin
            moves_q     <= moves_q - CW'(1);
            rd_idx_q    <= down_q ? rd_idx_q - AW'(1) : rd_idx_q + AW'(1);
            pend_addr_q <= down_q ? rd_idx_q + AW'(1) : rd_idx_q - AW'(1);
          end
          if (finish) begin
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            state_q                <= S_IDLE;
            count_q                <= next_count_q;
            out_data_q.status      <= status_q;
            out_data_q.entry_count <= 7'(next_count_q);
            if (rd_q) begin
              out_data_q.entry_from_tree <= ram_rd_data_i.from_tree;
              out_data_q.entry_handle    <= ram_rd_data_i.handle;
            end else begin
              out_data_q.entry_from_tree <= 1'b0;
              out_data_q.entry_handle    <= '0;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== design/dle_checker.sv =====
`default_nettype none

// Port-level checks on the duplicate list editor.
module dle_checker #(
  parameter int unsigned DEPTH = 64
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_stall_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire dle_pkg::rsp_t                  out_data_o
);

  // A stalled response stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled response changed");

  // The sequencer is busy in the cycle after it takes a request.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken twice in a row");

  // Only a successful read returns entry contents.
  a_no_data_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != dle_pkg::ST_OK) |->
      !out_data_o.entry_from_tree && (out_data_o.entry_handle == '0))
    else $error("entry data on a failed request");

  // A full list reports exactly DEPTH entries.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == dle_pkg::ST_FULL) |->
      (out_data_o.entry_count == 7'(DEPTH)))
    else $error("full status with wrong count");

endmodule

bind duplicate_list_editor dle_checker #(.DEPTH(DEPTH)) u_dle_checker (.*);

`default_nettype wire

// ===== tb/tb_duplicate_list_editor.sv =====
`default_nettype none

module tb_duplicate_list_editor;
  import dle_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE      = DEPTH + 8;
  localparam int unsigned MAX_REPORTS = 10;

  // The one opcode the package leaves unassigned.
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef enum int {MIX_GROW, MIX_CHURN, MIX_SHRINK, MIX_EVEN} mix_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req_data  = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TAKE_TREE;
  logic                 cfg_data  = 1'b0;

  // Shadow copy of the list and of the enables.
  logic        shadow_src [DEPTH];
  logic [31:0] shadow_hnd [DEPTH];
  int unsigned shadow_len = 0;
  logic        take_tree  = 1'b1;
  logic        take_txn   = 1'b1;

  // Responses predicted for accepted requests, oldest first.
  rsp_t pending_rsp [$];

  logic [2:0] op_order [8] = '{OP_TREE_APPEND, OP_OVR_ALL, OP_OVERWRITE, OP_INSERT,
                               OP_ERASE, OP_CLEAR, OP_READ, OP_UNUSED};

  bit          quiet     = 1'b0;
  int unsigned n_cycles  = 0;
  int unsigned n_sent    = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors  = 0;
  int unsigned n_full    = 0;
  int unsigned n_badref  = 0;
  int unsigned n_ignored = 0;
  int unsigned peak_len  = 0;

  duplicate_list_editor #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_stall_o (req_stall),
    .in_data_i  (req_data),
    .out_valid_o(rsp_valid),
    .out_stall_i(rsp_stall),
    .out_data_o (rsp_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Insert an entry at pos, shifting the tail up by one.
  function automatic logic [1:0] place_entry(int unsigned pos, logic src, logic [31:0] h);
    if (shadow_len >= DEPTH) return ST_FULL;
    if (pos > shadow_len) pos = shadow_len;
    for (int unsigned i = shadow_len; i > pos; i--) begin
      shadow_src[i] = shadow_src[i-1];
      shadow_hnd[i] = shadow_hnd[i-1];
    end
    shadow_src[pos] = src;
    shadow_hnd[pos] = h;
    shadow_len++;
    return ST_OK;
  endfunction

  // Apply one request to the shadow list and return the response it gives.
  function automatic rsp_t predict_rsp(req_t r);
    rsp_t        rsp;
    logic [2:0]  op;
    int unsigned rix;
    rsp = '0;
    rsp.status = ST_OK;
    op = r.opcode;
    rix = 32'(r.ref_index);
    // Transaction edits are dropped when disabled or not visible.
    if ((op inside {OP_OVR_ALL, OP_OVERWRITE, OP_INSERT, OP_ERASE}) &&
        (!take_txn || !r.visible))
      op = OP_UNUSED;
    case (op)
      OP_TREE_APPEND: begin
        if (!take_tree) rsp.status = ST_IGNORED;
        else rsp.status = place_entry(shadow_len, 1'b1, r.handle);
      end
      OP_OVR_ALL: begin
        shadow_len = 0;
        rsp.status = place_entry(0, 1'b0, r.handle);
      end
      OP_OVERWRITE: begin
        if (rix == 0) begin
          shadow_len = 0;
          rsp.status = place_entry(0, 1'b0, r.handle);
        end else if (rix > shadow_len) begin
          rsp.status = ST_BADREF;
        end else begin
          shadow_src[rix-1] = 1'b0;
          shadow_hnd[rix-1] = r.handle;
        end
      end
      OP_INSERT: begin
        case (r.place_mode)
          PM_FIRST: rsp.status = place_entry(0, 1'b0, r.handle);
          PM_BEFORE: begin
            if (rix == 0 || rix - 1 > shadow_len) rsp.status = ST_BADREF;
            else rsp.status = place_entry(rix - 1, 1'b0, r.handle);
          end
          PM_AFTER: begin
            rsp.status = place_entry(rix >= shadow_len ? shadow_len : rix, 1'b0, r.handle);
          end
          default: rsp.status = place_entry(shadow_len, 1'b0, r.handle);
        endcase
      end
      OP_ERASE: begin
        if (rix == 0) begin
          shadow_len = 0;
        end else if (rix > shadow_len) begin
          rsp.status = ST_BADREF;
        end else begin
          for (int unsigned i = rix - 1; i + 1 < shadow_len; i++) begin
            shadow_src[i] = shadow_src[i+1];
            shadow_hnd[i] = shadow_hnd[i+1];
          end
          shadow_len--;
        end
      end
      OP_CLEAR: shadow_len = 0;
      OP_READ: begin
        if (rix == 0 || rix > shadow_len) begin
          rsp.status = ST_BADREF;
        end else begin
          rsp.entry_from_tree = shadow_src[rix-1];
          rsp.entry_handle    = shadow_hnd[rix-1];
        end
      end
      default: rsp.status = ST_IGNORED;
    endcase
    rsp.entry_count = 7'(shadow_len);
    return rsp;
  endfunction

  function automatic req_t make_req(logic [2:0] op, logic [1:0] pm, logic [6:0] rix,
                                    logic [31:0] h, logic vis);
    req_t r;
    r.opcode     = op;
    r.place_mode = pm;
    r.ref_index  = rix;
    r.handle     = h;
    r.visible    = vis;
    return r;
  endfunction

  // Random request; the mix decides whether the list tends to grow or shrink.
  function automatic req_t random_req(mix_e mix);
    req_t        r;
    int unsigned w [8];
    int unsigned acc;
    int unsigned pick;
    r.place_mode = 2'($urandom_range(0, 3));
    r.handle     = $urandom;
    r.visible    = ($urandom_range(0, 99) < 94);
    r.opcode     = OP_UNUSED;
    // Mostly references near the current length, sometimes anything.
    pick = $urandom_range(0, 99);
    if (pick < 80) r.ref_index = 7'($urandom_range(0, shadow_len + 1));
    else if (pick < 95) r.ref_index = 7'($urandom_range(0, DEPTH));
    else r.ref_index = 7'($urandom_range(0, 127));
    // Weights in op_order order.
    case (mix)
      MIX_GROW:   w = '{40, 0, 6, 40, 5, 0, 8, 1};
      MIX_CHURN:  w = '{20, 1, 10, 25, 25, 1, 16, 2};
      MIX_SHRINK: w = '{8, 3, 10, 10, 45, 3, 20, 1};
      default:    w = '{15, 4, 12, 25, 17, 4, 20, 3};
    endcase
    pick = $urandom_range(0, 99);
    acc = 0;
    for (int i = 0; i < 8; i++) begin
      acc += w[i];
      if (pick < acc) begin
        r.opcode = op_order[i];
        break;
      end
    end
    return r;
  endfunction

  // Send one request, with an occasional gap, and record what it should give.
  task automatic send_req(req_t r);
    rsp_t want;
    if (!quiet && $urandom_range(0, 99) < 6) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (req_stall);
    want = predict_rsp(r);
    pending_rsp.push_back(want);
    n_sent++;
    if (shadow_len > peak_len) peak_len = shadow_len;
    case (want.status)
      ST_FULL:    n_full++;
      ST_BADREF:  n_badref++;
      ST_IGNORED: n_ignored++;
      default: ;
    endcase
  endtask

  task automatic send_random(mix_e mix, int unsigned count);
    repeat (count) send_req(random_req(mix));
  endtask

  // Stop sending and wait until every predicted response has been seen.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_TAKE_TREE) take_tree = val;
    else take_txn = val;
  endtask

  // Edges of every operation on a short list.
  task automatic test_directed_cases();
    send_req(make_req(OP_READ, PM_LAST, 7'd1, 32'h0, 1'b1));
    send_req(make_req(OP_ERASE, PM_LAST, 7'd0, 32'h0, 1'b1));
    send_req(make_req(OP_TREE_APPEND, PM_LAST, 7'd0, 32'h0000_0000, 1'b0));
    send_req(make_req(OP_TREE_APPEND, PM_AFTER, 7'd127, 32'hFFFF_FFFF, 1'b1));
    send_req(make_req(OP_INSERT, PM_FIRST, 7'd0, 32'hA5A5_A5A5, 1'b1));
    send_req(make_req(OP_INSERT, PM_LAST, 7'd0, 32'h5A5A_5A5A, 1'b1));
    // Insert before: no reference, past the end, just past the end, first.
    send_req(make_req(OP_INSERT, PM_BEFORE, 7'd0, 32'h1111_1111, 1'b1));
    send_req(make_req(OP_INSERT, PM_BEFORE, 7'd6, 32'h2222_2222, 1'b1));
    send_req(make_req(OP_INSERT, PM_BEFORE, 7'd5, 32'h3333_3333, 1'b1));
    send_req(make_req(OP_INSERT, PM_BEFORE, 7'd1, 32'h4444_4444, 1'b1));
    // Insert after: no reference goes first, a far reference appends.
    send_req(make_req(OP_INSERT, PM_AFTER, 7'd0, 32'h5555_5555, 1'b1));
    send_req(make_req(OP_INSERT, PM_AFTER, 7'd100, 32'h6666_6666, 1'b1));
    send_req(make_req(OP_INSERT, PM_AFTER, 7'd2, 32'h7777_7777, 1'b1));
    send_req(make_req(OP_OVERWRITE, PM_LAST, 7'd9, 32'hDEAD_BEEF, 1'b1));
    send_req(make_req(OP_OVERWRITE, PM_LAST, 7'd10, 32'h0BAD_0BAD, 1'b1));
    send_req(make_req(OP_READ, PM_LAST, 7'd9, 32'h0, 1'b0));
    send_req(make_req(OP_READ, PM_LAST, 7'd1, 32'h0, 1'b1));
    send_req(make_req(OP_READ, PM_LAST, 7'd0, 32'h0, 1'b1));
    send_req(make_req(OP_READ, PM_LAST, 7'd127, 32'h0, 1'b1));
    send_req(make_req(OP_ERASE, PM_LAST, 7'd3, 32'h0, 1'b1));
    send_req(make_req(OP_ERASE, PM_LAST, 7'd9, 32'h0, 1'b1));
    // Invisible transaction edit and the unused opcode are both ignored.
    send_req(make_req(OP_INSERT, PM_FIRST, 7'd0, 32'hCAFE_F00D, 1'b0));
    send_req(make_req(OP_UNUSED, PM_LAST, 7'd1, 32'h1234_5678, 1'b1));
    send_req(make_req(OP_OVERWRITE, PM_LAST, 7'd0, 32'h8888_8888, 1'b1));
    send_req(make_req(OP_OVR_ALL, PM_LAST, 7'd0, 32'h9999_9999, 1'b1));
    send_req(make_req(OP_CLEAR, PM_LAST, 7'd0, 32'h0, 1'b0));
    send_req(make_req(OP_READ, PM_LAST, 7'd1, 32'h0, 1'b1));
  endtask

  // Fill the list to the top, hit the full case in every form, shift at full depth.
  task automatic test_full_list();
    req_t r;
    while (shadow_len < DEPTH) begin
      r = random_req(MIX_GROW);
      r.opcode  = ($urandom_range(0, 1) != 0) ? OP_INSERT : OP_TREE_APPEND;
      r.visible = 1'b1;
      send_req(r);
    end
    send_req(make_req(OP_TREE_APPEND, PM_LAST, 7'd0, $urandom, 1'b1));
    send_req(make_req(OP_INSERT, PM_LAST, 7'd0, $urandom, 1'b1));
    send_req(make_req(OP_INSERT, PM_FIRST, 7'd0, $urandom, 1'b1));
    send_req(make_req(OP_INSERT, PM_BEFORE, 7'd1, $urandom, 1'b1));
    send_req(make_req(OP_INSERT, PM_AFTER, 7'd64, $urandom, 1'b1));
    send_req(make_req(OP_READ, PM_LAST, 7'd64, 32'h0, 1'b1));
    send_req(make_req(OP_OVERWRITE, PM_LAST, 7'd64, $urandom, 1'b1));
    send_req(make_req(OP_ERASE, PM_LAST, 7'd1, 32'h0, 1'b1));
    send_req(make_req(OP_INSERT, PM_FIRST, 7'd0, $urandom, 1'b1));
    send_req(make_req(OP_ERASE, PM_LAST, 7'd65, 32'h0, 1'b1));
    send_req(make_req(OP_ERASE, PM_LAST, 7'd64, 32'h0, 1'b1));
    send_req(make_req(OP_READ, PM_LAST, 7'd32, 32'h0, 1'b1));
    send_req(make_req(OP_OVR_ALL, PM_LAST, 7'd0, $urandom, 1'b1));
  endtask

  task automatic test_random_mix();
    send_random(MIX_GROW, 250);
    send_random(MIX_CHURN, 200);
    send_random(MIX_SHRINK, 150);
    send_random(MIX_EVEN, 200);
  endtask

  // Every combination of the two enables, ending with both set again.
  task automatic test_enable_settings();
    for (int k = 0; k < 4; k++) begin
      wait_drained();
      write_cfg(CFG_TAKE_TREE, k[1]);
      write_cfg(CFG_TAKE_TXN, k[0]);
      send_random(k == 1 ? MIX_GROW : MIX_EVEN, 70);
    end
  endtask

  // Bursts separated by a full drain of the response side.
  task automatic test_drain_pause();
    repeat (3) begin
      send_random(MIX_EVEN, 20);
      wait_drained();
    end
  endtask

  task automatic test_no_idle_run();
    quiet = 1'b1;
    send_random(MIX_CHURN, 150);
    quiet = 1'b0;
  endtask

  // Check each response against the oldest prediction; stall now and then.
  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst_n) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("unexpected response: status %0d count %0d tree %0b handle %h",
                     rsp_data.status, rsp_data.entry_count, rsp_data.entry_from_tree,
                     rsp_data.entry_handle);
        end else begin
          want = pending_rsp.pop_front();
          n_checked++;
          if (want.status != rsp_data.status || want.entry_count != rsp_data.entry_count ||
              want.entry_from_tree != rsp_data.entry_from_tree ||
              want.entry_handle != rsp_data.entry_handle) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("response %0d mismatch: want %0d/%0d/%0b/%h got %0d/%0d/%0b/%h",
                       n_checked, want.status, want.entry_count, want.entry_from_tree,
                       want.entry_handle, rsp_data.status, rsp_data.entry_count,
                       rsp_data.entry_from_tree, rsp_data.entry_handle);
          end
        end
      end
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 6);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb_duplicate_list_editor: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_full_list();
    test_random_mix();
    test_enable_settings();
    test_drain_pause();
    test_no_idle_run();
    wait_drained();
    $display("ran %0d requests, %0d responses checked, list reached %0d of %0d entries",
             n_sent, n_checked, peak_len, DEPTH);
    $display("outcomes seen: %0d full, %0d bad reference, %0d ignored; %0d mismatches",
             n_full, n_badref, n_ignored, n_errors);
    if (n_errors == 0) begin
      $display("tb_duplicate_list_editor: done, clean");
    end else begin
      $display("tb_duplicate_list_editor: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
